// ----- rtl/core/cdg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the curriculum difficulty gate.
// No dependencies; every module of the block imports this package.
package cdg_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = 10;
	localparam int Q_W         = 16;
	localparam int FRAC_W      = 9;
	localparam int CFG_IDX_W   = 3;

	// Q8.8 constants
	localparam logic [Q_W-1:0] Q_HALF     = 16'd128;
	localparam logic [Q_W-1:0] Q_ONE      = 16'd256;
	localparam logic [Q_W-1:0] Q_ONE_HALF = 16'd384;
	localparam logic [Q_W-1:0] Q_TENTH    = 16'd26;
	localparam logic [7:0]     W_NEW      = 8'd77;
	localparam logic [7:0]     W_OLD      = 8'd179;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_EPOCH  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_WARMUP = 2'd0,
		PH_EASY   = 2'd1,
		PH_MEDIUM = 2'd2,
		PH_FULL   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		STRAT_NONE    = 2'd0,
		STRAT_SELF    = 2'd1,
		STRAT_TEACHER = 2'd2,
		STRAT_LINEAR  = 2'd3
	} strategy_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRATEGY   = 3'd0,
		REG_WARMUP     = 3'd1,
		REG_INIT_PACE  = 3'd2,
		REG_PACE_INC   = 3'd3,
		REG_PACE_MAX   = 3'd4,
		REG_INIT_FRAC  = 3'd5,
		REG_GROWTH     = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]       command;
		logic [IDX_W-1:0] sample_index;
		logic [Q_W-1:0]   loss;
	} in_item_t;

	typedef struct packed {
		logic           include_res;
		logic [Q_W-1:0] difficulty;
		logic           scored;
		logic [1:0]     phase;
		logic [Q_W-1:0] threshold;
		logic           index_error;
	} out_item_t;

	// One table entry: scored flag with the difficulty
	typedef struct packed {
		logic           scored;
		logic [Q_W-1:0] diff;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{scored: 1'b0, diff: Q_HALF};

	typedef struct packed {
		logic                 en;
		logic [CFG_IDX_W-1:0] index;
		logic [Q_W-1:0]       data;
	} cfg_write_t;

	// Epoch sequencing from the controller to the scheduler
	typedef struct packed {
		logic step_count;
		logic step_apply;
	} sched_ctrl_t;

	typedef struct packed {
		phase_t         phase;
		logic [Q_W-1:0] threshold;
		strategy_t      strategy;
	} sched_status_t;

endpackage

// ----- rtl/core/cdg_table_ram.sv -----
`timescale 1ns / 1ps
// Difficulty table memory: one write port, one read port, registered read data.
// Depends on cdg_pkg for the entry type and table depth.
module cdg_table_ram (
	input  logic                    clk,
	input  logic                    we,
	input  logic [cdg_pkg::IDX_W-1:0] waddr,
	input  cdg_pkg::entry_t         wdata,
	input  logic                    re,
	input  logic [cdg_pkg::IDX_W-1:0] raddr,
	output cdg_pkg::entry_t         rdata
);
	import cdg_pkg::*;

	entry_t mem [TABLE_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/cdg_sched.sv -----
`timescale 1ns / 1ps
// Configuration registers and the epoch schedule (epoch count, pace, threshold, phase).
// Depends on cdg_pkg.
module cdg_sched (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cdg_pkg::cfg_write_t    cfg,
	input  cdg_pkg::sched_ctrl_t   ctrl,
	output cdg_pkg::sched_status_t status
);
	import cdg_pkg::*;

	strategy_t         strategy_q;
	logic [Q_W-1:0]    warmup_q;
	logic [Q_W-1:0]    pace_inc_q;
	logic [Q_W-1:0]    pace_max_q;
	logic [FRAC_W-1:0] init_frac_q;
	logic [FRAC_W-1:0] growth_q;
	logic [Q_W-1:0]    epoch_q;
	logic [Q_W-1:0]    pace_q;
	logic [Q_W-1:0]    thr_q;
	phase_t            phase_q;

	logic [Q_W-1:0]    nxt_pace;
	logic [Q_W-1:0]    nxt_thr;
	phase_t            nxt_phase;
	logic [Q_W:0]      pace_sum;
	logic [Q_W:0]      thr_sum;
	logic [24:0]       prod;
	logic [25:0]       frac_sum;

	assign pace_sum = {1'b0, pace_q} + {1'b0, pace_inc_q};
	assign thr_sum  = {1'b0, thr_q} + {1'b0, Q_TENTH};
	assign prod     = 25'(epoch_q) * 25'(growth_q);
	assign frac_sum = {1'b0, prod} + 26'(init_frac_q);

	// Work out pace, threshold and phase for the new epoch
	always_comb begin
		nxt_pace  = pace_q;
		nxt_thr   = thr_q;
		nxt_phase = phase_q;
		if (phase_q == PH_WARMUP) begin
			if (epoch_q >= warmup_q) begin
				nxt_phase = PH_EASY;
			end
		end else begin
			case (strategy_q)
				STRAT_SELF: begin
					if (pace_sum > {1'b0, pace_max_q}) begin
						nxt_pace  = pace_max_q;
						nxt_phase = PH_FULL;
					end else begin
						nxt_pace = pace_sum[Q_W-1:0];
					end
					nxt_thr = nxt_pace;
				end
				STRAT_TEACHER: begin
					if (frac_sum > 26'(Q_ONE)) begin
						nxt_thr = Q_ONE;
					end else begin
						nxt_thr = frac_sum[Q_W-1:0];
					end
				end
				default: begin
					if (thr_sum > {1'b0, Q_ONE_HALF}) begin
						nxt_thr   = Q_ONE_HALF;
						nxt_phase = PH_FULL;
					end else begin
						nxt_thr = thr_sum[Q_W-1:0];
					end
				end
			endcase
			// Full phase sticks; otherwise classify by threshold
			if (nxt_phase != PH_FULL) begin
				if (nxt_thr < Q_HALF) begin
					nxt_phase = PH_EASY;
				end else if (nxt_thr < Q_ONE) begin
					nxt_phase = PH_MEDIUM;
				end else begin
					nxt_phase = PH_FULL;
				end
			end
		end
	end

	// Hold configuration and schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q  <= STRAT_SELF;
			warmup_q    <= '0;
			pace_inc_q  <= Q_TENTH;
			pace_max_q  <= 16'd512;
			init_frac_q <= 9'd51;
			growth_q    <= 9'd26;
			epoch_q     <= '0;
			pace_q      <= Q_HALF;
			thr_q       <= Q_HALF;
			phase_q     <= PH_EASY;
		end else begin
			if (cfg.en) begin
				case (cfg_reg_t'(cfg.index))
					REG_STRATEGY: strategy_q <= strategy_t'(cfg.data[1:0]);
					REG_WARMUP: begin
						warmup_q <= cfg.data;
						if (epoch_q == '0) begin
							phase_q <= (cfg.data != '0) ? PH_WARMUP : PH_EASY;
						end
					end
					// Starting pace loads pace and threshold directly
					REG_INIT_PACE: begin
						pace_q <= cfg.data;
						thr_q  <= cfg.data;
					end
					REG_PACE_INC:  pace_inc_q  <= cfg.data;
					REG_PACE_MAX:  pace_max_q  <= cfg.data;
					REG_INIT_FRAC: init_frac_q <= cfg.data[FRAC_W-1:0];
					REG_GROWTH:    growth_q    <= cfg.data[FRAC_W-1:0];
					default: ;
				endcase
			end
			// Advance the epoch count, saturating
			if (ctrl.step_count && (epoch_q != {Q_W{1'b1}})) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if (ctrl.step_apply) begin
				pace_q  <= nxt_pace;
				thr_q   <= nxt_thr;
				phase_q <= nxt_phase;
			end
		end
	end

	assign status.phase     = phase_q;
	assign status.threshold = thr_q;
	assign status.strategy  = strategy_q;

endmodule

// ----- rtl/core/curriculum_difficulty_gate.sv -----
`timescale 1ns / 1ps
// Curriculum difficulty gate: update, query and read pass through ST_EXEC (table
// read then write-back); done strobes in the cycle after, one per item. Start epoch
// passes ST_EPOCH_CALC then ST_EPOCH_DONE. Busy holds until done; then a new item may
// follow at once. After reset a clearing pass writes every entry (busy high); config
// writes are taken throughout. Results cannot be stalled by the receiver.
module curriculum_difficulty_gate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  cdg_pkg::in_item_t                 item,
	output logic                              done,
	output cdg_pkg::out_item_t                result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cdg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cdg_pkg::Q_W-1:0]           cfg_data
);
	import cdg_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_EPOCH_CALC,
		ST_EPOCH_DONE
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_addr_q;
	cmd_t             cmd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [Q_W-1:0]   loss_s1;
	logic             err_s1;
	logic             done_q;
	out_item_t        result_q;

	logic             accept;
	logic             item_err;
	cfg_write_t       cfg_wr;
	sched_ctrl_t      sched_ctrl;
	sched_status_t    sched_st;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;
	logic [24:0]      blend_sum;
	logic [Q_W-1:0]   blend;
	entry_t           upd_entry;
	logic             inc;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign item_err  = ({1'b0, item.sample_index} >= (IDX_W+1)'(TABLE_DEPTH));

	assign cfg_wr.en    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign sched_ctrl.step_count = accept && (cmd_t'(item.command) == CMD_EPOCH);
	assign sched_ctrl.step_apply = (state_q == ST_EPOCH_CALC);

	cdg_sched u_sched (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_wr),
		.ctrl   (sched_ctrl),
		.status (sched_st)
	);

	// Blend a new loss into the stored difficulty, rounded half up
	assign blend_sum = 25'(loss_s1) * 25'(W_NEW) + 25'(ram_rdata.diff) * 25'(W_OLD)
		+ 25'(Q_HALF);
	assign blend     = blend_sum[Q_W+7:8];

	always_comb begin
		upd_entry.scored = 1'b1;
		upd_entry.diff   = ram_rdata.scored ? blend : loss_s1;
	end

	// Write back an update, or sweep the table after reset
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata = upd_entry;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = ENTRY_RESET;
		end else if (state_q == ST_EXEC) begin
			ram_we = (cmd_s1 == CMD_UPDATE) && !err_s1;
		end
	end

	cdg_table_ram u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (item.sample_index),
		.rdata (ram_rdata)
	);

	// Query answer from the entry as it stands
	assign inc = (cmd_s1 == CMD_QUERY) &&
		((sched_st.phase == PH_WARMUP) || (sched_st.strategy == STRAT_NONE) ||
		 (sched_st.phase == PH_FULL) || (ram_rdata.diff <= sched_st.threshold));

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_t'(item.command);
			idx_s1  <= item.sample_index;
			loss_s1 <= item.loss;
			err_s1  <= item_err;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			result_q.phase     <= sched_st.phase;
			result_q.threshold <= sched_st.threshold;
			result_q.index_error <= err_s1;
			if (err_s1) begin
				result_q.include_res <= 1'b0;
				result_q.difficulty  <= '0;
				result_q.scored      <= 1'b0;
			end else if (cmd_s1 == CMD_UPDATE) begin
				result_q.include_res <= 1'b0;
				result_q.difficulty  <= upd_entry.diff;
				result_q.scored      <= 1'b1;
			end else begin
				result_q.include_res <= inc;
				result_q.difficulty  <= ram_rdata.diff;
				result_q.scored      <= ram_rdata.scored;
			end
		end else if (state_q == ST_EPOCH_DONE) begin
			result_q.include_res <= 1'b0;
			result_q.difficulty  <= '0;
			result_q.scored      <= 1'b0;
			result_q.phase       <= sched_st.phase;
			result_q.threshold   <= sched_st.threshold;
			result_q.index_error <= 1'b0;
		end
	end

	// Control: clearing pass, command sequencing, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= (cmd_t'(item.command) == CMD_EPOCH) ? ST_EPOCH_CALC
							: ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_EPOCH_CALC: begin
					state_q <= ST_EPOCH_DONE;
				end
				ST_EPOCH_DONE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// An accepted item always makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting an item");

	// Results are never back to back
	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// A flagged index reports no table contents
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.index_error) |->
		(result.difficulty == '0 && !result.scored && !result.include_res))
		else $error("index error result carries table data");

	// The table is written only while sweeping or finishing an item
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_EXEC))
		else $error("table written outside its write window");

endmodule

// ----- tb/sv/tb_curriculum_difficulty_gate.sv -----
`timescale 1ns / 1ps
// Self-checking bench for curriculum_difficulty_gate: directed table, then random traffic.
// Keeps its own model of the difficulty table, epoch schedule and phase; imports cdg_pkg only.
module tb_curriculum_difficulty_gate;
	import cdg_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 10;
	localparam int SETTLE = 4;
	localparam int N_SEG = 8;
	localparam int SEG_ITEMS = 50;
	localparam longint LIMIT_NS = 1_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// Register reset values
	localparam int unsigned RST_PACE_MAX = 512;
	localparam int unsigned RST_INIT_FRAC = 51;

	typedef struct {
		bit                   is_cfg;
		bit                   typed;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [Q_W-1:0]       data;
		in_item_t             it;
		out_item_t            want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [Q_W-1:0] cfg_data;

	curriculum_difficulty_gate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Model state: table, schedule and register copies
	logic [Q_W-1:0] tab_diff [TABLE_DEPTH];
	bit             tab_scored [TABLE_DEPTH];
	int unsigned    epoch_ctr;
	int unsigned    pace_q;
	int unsigned    thr_q;
	phase_t         phase_q;
	strategy_t      c_strat;
	int unsigned    c_warm, c_ipace, c_pinc, c_pmax, c_ifrac, c_grow;

	out_item_t expected_results [$];
	dir_row_t  dir_q [$];
	out_item_t want_r;
	int n_sent = 0;
	int n_checked = 0;
	int n_cfg = 0;
	int n_err = 0;

	function automatic void gate_reset();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tab_diff[i] = Q_HALF;
			tab_scored[i] = 1'b0;
		end
		c_strat = STRAT_SELF;
		c_warm = 0;
		c_ipace = 32'(Q_HALF);
		c_pinc = 32'(Q_TENTH);
		c_pmax = RST_PACE_MAX;
		c_ifrac = RST_INIT_FRAC;
		c_grow = 32'(Q_TENTH);
		epoch_ctr = 0;
		pace_q = c_ipace;
		thr_q = c_ipace;
		phase_q = (c_warm != 0) ? PH_WARMUP : PH_EASY;
	endfunction

	function automatic void gate_config(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
		case (idx)
			REG_STRATEGY: c_strat = strategy_t'(data[1:0]);
			REG_WARMUP: begin
				c_warm = 32'(data);
				if (epoch_ctr == 0)
					phase_q = (c_warm != 0) ? PH_WARMUP : PH_EASY;
			end
			REG_INIT_PACE: begin
				c_ipace = 32'(data);
				pace_q = 32'(data);
				thr_q = 32'(data);
			end
			REG_PACE_INC: c_pinc = 32'(data);
			REG_PACE_MAX: c_pmax = 32'(data);
			REG_INIT_FRAC: c_ifrac = 32'(data[FRAC_W-1:0]);
			REG_GROWTH: c_grow = 32'(data[FRAC_W-1:0]);
			default: ;
		endcase
	endfunction

	// Epoch step: saturating counter, warmup exit, strategy schedule, phase
	function automatic void advance_epoch();
		int unsigned nxt;
		if (epoch_ctr < 32'hFFFF)
			epoch_ctr++;
		if (phase_q == PH_WARMUP) begin
			if (epoch_ctr >= c_warm)
				phase_q = PH_EASY;
			return;
		end
		case (c_strat)
			STRAT_SELF: begin
				nxt = pace_q + c_pinc;
				if (nxt > c_pmax) begin
					nxt = c_pmax;
					phase_q = PH_FULL;
				end
				pace_q = nxt;
				thr_q = nxt;
			end
			STRAT_TEACHER: begin
				nxt = c_ifrac + epoch_ctr * c_grow;
				if (nxt > Q_ONE)
					nxt = 32'(Q_ONE);
				thr_q = nxt;
			end
			default: begin
				nxt = thr_q + Q_TENTH;
				if (nxt > Q_ONE_HALF) begin
					nxt = 32'(Q_ONE_HALF);
					phase_q = PH_FULL;
				end
				thr_q = nxt;
			end
		endcase
		if (phase_q != PH_FULL) begin
			if (thr_q < Q_HALF)
				phase_q = PH_EASY;
			else if (thr_q < Q_ONE)
				phase_q = PH_MEDIUM;
			else
				phase_q = PH_FULL;
		end
	endfunction

	function automatic out_item_t gate_predict(in_item_t it);
		out_item_t r;
		int unsigned ix;
		int unsigned blend;
		r = '0;
		ix = 32'(it.sample_index);
		if (it.command == CMD_EPOCH) begin
			advance_epoch();
		end else if (ix >= TABLE_DEPTH) begin
			r.index_error = 1'b1;
		end else begin
			if (it.command == CMD_UPDATE) begin
				if (tab_scored[ix]) begin
					blend = (int'(W_NEW) * int'(it.loss) + int'(W_OLD) * int'(tab_diff[ix])
						+ 128) >> 8;
					tab_diff[ix] = 16'(blend);
				end else begin
					tab_diff[ix] = it.loss;
					tab_scored[ix] = 1'b1;
				end
			end
			r.difficulty = tab_diff[ix];
			r.scored = tab_scored[ix];
			if (it.command == CMD_QUERY) begin
				if (phase_q == PH_WARMUP || c_strat == STRAT_NONE || phase_q == PH_FULL)
					r.include_res = 1'b1;
				else
					r.include_res = (tab_diff[ix] <= thr_q);
			end
		end
		r.phase = phase_q;
		r.threshold = 16'(thr_q);
		return r;
	endfunction

	function automatic out_item_t mk_out(int inc, logic [Q_W-1:0] d, int sc, phase_t ph,
			logic [Q_W-1:0] thr);
		out_item_t r;
		r = '0;
		r.include_res = inc[0];
		r.difficulty = d;
		r.scored = sc[0];
		r.phase = ph;
		r.threshold = thr;
		return r;
	endfunction

	function automatic void d_row(int typed, cmd_t cmd, int unsigned idx, int unsigned loss,
			out_item_t want);
		dir_row_t row;
		row.is_cfg = 1'b0;
		row.typed = typed[0];
		row.reg_idx = '0;
		row.data = '0;
		row.it.command = cmd;
		row.it.sample_index = IDX_W'(idx);
		row.it.loss = Q_W'(loss);
		row.want = want;
		dir_q.push_back(row);
	endfunction

	function automatic void d_cfg(logic [CFG_IDX_W-1:0] r, int unsigned v);
		dir_row_t row;
		row.is_cfg = 1'b1;
		row.typed = 1'b0;
		row.reg_idx = r;
		row.data = Q_W'(v);
		row.it = '0;
		row.want = '0;
		dir_q.push_back(row);
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 36)
			it.command = CMD_UPDATE;
		else if (r < 74)
			it.command = CMD_QUERY;
		else if (r < 94)
			it.command = CMD_READ;
		else
			it.command = CMD_EPOCH;
		// Mostly a small pool so updates and queries meet the same entries
		r = $urandom_range(0, 99);
		if (r < 70)
			it.sample_index = IDX_W'($urandom_range(0, 15));
		else if (r < 80)
			it.sample_index = $urandom_range(0, 1) ? '1 : '0;
		else
			it.sample_index = IDX_W'($urandom);
		// Losses near the thresholds, the extremes, or anything
		r = $urandom_range(0, 99);
		if (r < 50)
			it.loss = Q_W'($urandom_range(0, 400));
		else if (r < 60)
			it.loss = $urandom_range(0, 1) ? '1 : '0;
		else
			it.loss = Q_W'($urandom);
		return it;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t ns MISMATCH %s: got %0h, want %0h", $time, what, got, want);
		n_err++;
	endtask

	// Present one item, hold it until the transfer, then record what it must produce
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		out_item_t pred;
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pred = gate_predict(it);
		expected_results.push_back(typed ? want : pred);
		n_sent++;
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Stop sending and wait until every outstanding result is back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		gate_config(idx, data);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report("result with nothing expected", 32'(result), 0);
			end else begin
				want_r = expected_results.pop_front();
				n_checked++;
				if (result.include_res !== want_r.include_res)
					report("include_res", 32'(result.include_res),
						32'(want_r.include_res));
				if (result.difficulty !== want_r.difficulty)
					report("difficulty", 32'(result.difficulty), 32'(want_r.difficulty));
				if (result.scored !== want_r.scored)
					report("scored", 32'(result.scored), 32'(want_r.scored));
				if (result.phase !== want_r.phase)
					report("phase", 32'(result.phase), 32'(want_r.phase));
				if (result.threshold !== want_r.threshold)
					report("threshold", 32'(result.threshold), 32'(want_r.threshold));
				if (result.index_error !== want_r.index_error)
					report("index_error", 32'(result.index_error),
						32'(want_r.index_error));
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("tb_curriculum_difficulty_gate NOT OK");
		$finish;
	end

	initial begin
		int unsigned s_strat, s_warm, s_ipace, s_pinc, s_pmax, s_ifrac, s_grow;
		int burst;
		bit quiet;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		gate_reset();

		// Directed table: reset state, extremes, blend, warmup and the none, self and teacher strategies
		d_row(1, CMD_READ, 0, 0, mk_out(0, Q_HALF, 0, PH_EASY, Q_HALF));
		d_row(1, CMD_QUERY, 0, 0, mk_out(1, Q_HALF, 0, PH_EASY, Q_HALF));
		d_row(1, CMD_UPDATE, TABLE_DEPTH - 1, 'hFFFF, mk_out(0, 16'hFFFF, 1, PH_EASY, Q_HALF));
		d_row(0, CMD_UPDATE, TABLE_DEPTH - 1, 0, '0);
		d_row(1, CMD_UPDATE, 0, 0, mk_out(0, 16'h0000, 1, PH_EASY, Q_HALF));
		d_row(1, CMD_QUERY, 0, 0, mk_out(1, 16'h0000, 1, PH_EASY, Q_HALF));
		d_row(0, CMD_UPDATE, 0, 'hFFFF, '0);
		d_row(0, CMD_QUERY, 0, 0, '0);
		d_row(0, CMD_UPDATE, 2, 32'(Q_HALF), '0);
		d_row(0, CMD_QUERY, 2, 0, '0);
		d_row(0, CMD_UPDATE, 3, Q_HALF + 1, '0);
		d_row(0, CMD_QUERY, 3, 0, '0);
		// Warmup is only reachable before the first epoch
		d_cfg(REG_WARMUP, 3);
		d_row(1, CMD_QUERY, 3, 0, mk_out(1, Q_HALF + 16'd1, 1, PH_WARMUP, Q_HALF));
		d_row(1, CMD_EPOCH, 0, 0, mk_out(0, 16'h0000, 0, PH_WARMUP, Q_HALF));
		d_row(0, CMD_EPOCH, 0, 0, '0);
		// Rewrite after the first epoch leaves the phase alone
		d_cfg(REG_WARMUP, 2);
		d_row(0, CMD_EPOCH, 0, 0, '0);
		d_cfg(REG_STRATEGY, 32'(STRAT_NONE));
		d_row(0, CMD_QUERY, 0, 0, '0);
		d_row(0, CMD_EPOCH, 0, 0, '0);
		d_cfg(REG_STRATEGY, 32'(STRAT_SELF));
		d_cfg(REG_PACE_INC, 0);
		d_row(0, CMD_EPOCH, 0, 0, '0);
		d_cfg(REG_INIT_PACE, 0);
		d_cfg(REG_STRATEGY, 32'(STRAT_TEACHER));
		d_cfg(REG_INIT_FRAC, 0);
		d_cfg(REG_GROWTH, 0);
		d_row(0, CMD_EPOCH, 0, 0, '0);
		d_row(0, CMD_QUERY, 0, 0, '0);
		d_cfg(REG_UNUSED, 'hFFFF);
		d_row(0, CMD_READ, 500, 'h1234, '0);
		d_row(0, CMD_UPDATE, TABLE_DEPTH - 1, 'h8000, '0);
		d_row(0, CMD_READ, TABLE_DEPTH - 1, 0, '0);

		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table; items wait out the clearing pass on busy
		foreach (dir_q[i]) begin
			if (dir_q[i].is_cfg) begin
				drain();
				cfg_write(dir_q[i].reg_idx, dir_q[i].data);
			end else begin
				send_item(dir_q[i].it, dir_q[i].typed, dir_q[i].want);
			end
		end

		// Random segments, each under a fresh setting; the last two force the caps
		for (int seg = 0; seg < N_SEG; seg++) begin
			drain();
			if (seg == N_SEG - 2) begin
				s_strat = 32'(STRAT_SELF);
				s_warm = 65535;
				s_ipace = 65535;
				s_pinc = 65535;
				s_pmax = 0;
				s_ifrac = 32'(Q_ONE);
				s_grow = 32'(Q_ONE);
			end else if (seg == N_SEG - 1) begin
				s_strat = 32'(STRAT_LINEAR);
				s_warm = 0;
				s_ipace = 0;
				s_pinc = 0;
				s_pmax = 0;
				s_ifrac = 0;
				s_grow = 0;
			end else begin
				s_strat = $urandom_range(0, 3);
				s_warm = $urandom_range(0, 16'hFFFF);
				s_ipace = $urandom_range(0, 180);
				s_pinc = $urandom_range(0, 30);
				s_pmax = $urandom_range(200, 16'hFFFF);
				s_ifrac = $urandom_range(0, 80);
				s_grow = $urandom_range(0, 3);
			end
			// Narrow registers get junk in their unused bits
			cfg_write(REG_STRATEGY, 16'(($urandom << 2) | s_strat));
			cfg_write(REG_WARMUP, 16'(s_warm));
			cfg_write(REG_PACE_INC, 16'(s_pinc));
			cfg_write(REG_PACE_MAX, 16'(s_pmax));
			cfg_write(REG_INIT_FRAC, 16'(($urandom << FRAC_W) | s_ifrac));
			cfg_write(REG_GROWTH, 16'(($urandom << FRAC_W) | s_grow));
			cfg_write(REG_INIT_PACE, 16'(s_ipace));

			quiet = (seg % 3 == 2);
			burst = $urandom_range(1, 12);
			for (int k = 0; k < SEG_ITEMS; k++) begin
				if (seg == 3 && k == SEG_ITEMS / 2)
					drain();
				send_item(rand_item(), 1'b0, '0);
				if (!quiet) begin
					burst--;
					if (burst == 0) begin
						idle_cycles($urandom_range(1, 8));
						burst = $urandom_range(1, 12);
					end
				end
			end
		end

		drain();
		$display("%0d items sent, %0d results checked, %0d register writes",
			n_sent, n_checked, n_cfg);
		$display("covered warmup, every strategy, blend rounding, caps and full phase");
		if (n_err == 0) begin
			$display("tb_curriculum_difficulty_gate OK");
		end else begin
			$display("%0d mismatches", n_err);
			$display("tb_curriculum_difficulty_gate NOT OK");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/cdg_pkg.sv
rtl/core/cdg_table_ram.sv
rtl/core/cdg_sched.sv
rtl/core/curriculum_difficulty_gate.sv
tb/sv/tb_curriculum_difficulty_gate.sv
